/* rtl/bvm_pkg.sv */
// Shared types and constants for the battery voltage monitor.
`default_nettype none
package bvm_pkg;

    localparam int MV_W      = 16;
    localparam int SHIFT_W   = 4;
    localparam int ACC_W     = 2 * MV_W;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD     = 3'd0,
        CFG_FULL_SCALE = 3'd1,
        CFG_SHIFT      = 3'd2,
        CFG_LOW_TH     = 3'd3,
        CFG_CRIT_TH    = 3'd4,
        CFG_HYST       = 3'd5
    } t_cfg_idx;

    // Battery level codes
    typedef enum logic [1:0] {
        LVL_OK   = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_CRIT = 2'd2
    } t_level;

    // Register reset values
    localparam logic [MV_W-1:0]    RST_PERIOD     = 16'd16;
    localparam logic [MV_W-1:0]    RST_FULL_SCALE = 16'd4800;
    localparam logic [SHIFT_W-1:0] RST_SHIFT      = 4'd4;
    localparam logic [MV_W-1:0]    RST_LOW_TH     = 16'd3500;
    localparam logic [MV_W-1:0]    RST_CRIT_TH    = 16'd3300;
    localparam logic [MV_W-1:0]    RST_HYST       = 16'd100;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [MV_W-1:0]    period;
        logic [MV_W-1:0]    full_scale;
        logic [SHIFT_W-1:0] shift;
        logic [MV_W-1:0]    low_th;
        logic [MV_W-1:0]    crit_th;
        logic [MV_W-1:0]    hyst;
    } t_cfg;

    // Scaled reading passed to the filter stage
    typedef struct packed {
        logic            used;
        logic [MV_W-1:0] mv;
    } t_mv_word;

endpackage
`default_nettype wire

/* rtl/bvm_in_if.sv */
// Input channel: one ADC sample word per frame.
`default_nettype none
interface bvm_in_if #(
    parameter int ADC_BITS = 10
) ();
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface
`default_nettype wire

/* rtl/bvm_out_if.sv */
// Output channel: filtered voltage, level and sample-used flag.
`default_nettype none
interface bvm_out_if import bvm_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MV_W-1:0] filtered_mv;
    logic [1:0]      battery_level;
    logic            sample_used;

    modport source (output valid, output filtered_mv, output battery_level,
                    output sample_used, input ready);
    modport sink   (input valid, input filtered_mv, input battery_level,
                    input sample_used, output ready);
endinterface
`default_nettype wire

/* rtl/bvm_scale.sv */
// Input register and ADC-code to millivolt scaling stage.
`default_nettype none
module bvm_scale import bvm_pkg::*; #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [ADC_BITS-1:0] i_sample,
    input  wire logic                i_used,
    input  wire logic [MV_W-1:0]     i_full_scale,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output t_mv_word                 o_word
);

    logic                     r_s0_valid;
    logic [ADC_BITS-1:0]      r_s0_sample;
    logic                     r_s0_used;
    logic                     r_s1_valid;
    t_mv_word                 r_s1_word;
    logic                     s0_ready;
    logic                     s1_ready;
    logic [ADC_BITS+MV_W-1:0] prod;
    t_mv_word                 n_s1_word;

    // Each stage moves when its successor has room
    assign s1_ready = !r_s1_valid || i_ready;
    assign s0_ready = !r_s0_valid || s1_ready;
    assign o_ready  = s0_ready;

    // mv = (sample * full_scale) >> ADC_BITS
    assign prod = {{MV_W{1'b0}}, r_s0_sample} * {{ADC_BITS{1'b0}}, i_full_scale};
    always_comb begin
        n_s1_word.used = r_s0_used;
        n_s1_word.mv   = prod[ADC_BITS+MV_W-1:ADC_BITS];
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_valid;
        end
        if (s0_ready && i_valid) begin
            r_s0_sample <= i_sample;
            r_s0_used   <= i_used;
        end
    end

    // Scaled word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= r_s0_valid;
        end
        if (s1_ready && r_s0_valid) begin
            r_s1_word <= n_s1_word;
        end
    end

    assign o_valid = r_s1_valid;
    assign o_word  = r_s1_word;

endmodule
`default_nettype wire

/* rtl/bvm_filter.sv */
// IIR filter update, hysteresis classification and result register.
`default_nettype none
module bvm_filter import bvm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_mv_word i_word,
    input  wire t_cfg     i_cfg,
    output logic          o_valid,
    input  wire logic     i_ready,
    output logic [MV_W-1:0] o_filtered_mv,
    output t_level        o_level,
    output logic          o_sample_used
);

    logic             r_out_valid;
    logic             r_out_used;
    logic [MV_W-1:0]  r_filt;
    t_level           r_level;
    logic [MV_W-1:0]  n_filt;
    t_level           n_level;
    logic             load;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] acc_sh;
    logic [MV_W:0]    crit_th;
    logic [MV_W:0]    low_th;

    assign o_ready = !r_out_valid || i_ready;
    assign load    = i_valid && o_ready;

    // Filter: (f*(2^k-1) + mv) >> k, written as ((f<<k) - f + mv) >> k
    assign acc    = ({{MV_W{1'b0}}, r_filt} << i_cfg.shift) - {{MV_W{1'b0}}, r_filt}
                    + {{MV_W{1'b0}}, i_word.mv};
    assign acc_sh = acc >> i_cfg.shift;

    // Thresholds, raised by hysteresis once the level has been entered
    assign crit_th = {1'b0, i_cfg.crit_th}
                     + ((r_level == LVL_CRIT) ? {1'b0, i_cfg.hyst} : {(MV_W+1){1'b0}});
    assign low_th  = {1'b0, i_cfg.low_th}
                     + ((r_level != LVL_OK) ? {1'b0, i_cfg.hyst} : {(MV_W+1){1'b0}});

    // Next filter value and level
    always_comb begin
        n_filt  = r_filt;
        n_level = r_level;
        if (i_word.used) begin
            if (r_filt == '0) begin
                n_filt = i_word.mv;    // no reading yet: load directly
            end else begin
                n_filt = acc_sh[MV_W-1:0];
            end
            if ({1'b0, n_filt} < crit_th) begin
                n_level = LVL_CRIT;
            end else if ({1'b0, n_filt} < low_th) begin
                n_level = LVL_LOW;
            end else begin
                n_level = LVL_OK;
            end
        end
    end

    // State and result register move together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_filt      <= '0;
            r_level     <= LVL_OK;
        end else begin
            r_out_valid <= load || (r_out_valid && !i_ready);
            if (load) begin
                r_filt  <= n_filt;
                r_level <= n_level;
            end
        end
        if (load) begin
            r_out_used <= i_word.used;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_filtered_mv = r_filt;
    assign o_level       = r_level;
    assign o_sample_used = r_out_used;

    // Skipped frame keeps the filter value
    a_skip_filt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !i_word.used) |=> $stable(r_filt))
        else $error("filter value changed on a skipped frame");

    // Skipped frame keeps the level
    a_skip_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !i_word.used) |=> $stable(r_level))
        else $error("level changed on a skipped frame");

    // Empty filter loads the new reading
    a_zero_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_word.used && r_filt == '0) |=> (r_filt == $past(i_word.mv)))
        else $error("empty filter did not load the reading");

endmodule
`default_nettype wire

/* rtl/battery_voltage_monitor.sv */
// Battery voltage monitor top level: config registers, frame phase, datapath.
// An accepted word passes the input, scaled-word and result registers in order.
// Throughput: one word per cycle while the output is ready; the filter state loop
// closes around the result register, the scaling multiply sits one stage earlier.
// Reset (synchronous, active low) restores the register defaults and clears
// the frame phase, the filter value and the level to OK.
`default_nettype none
module battery_voltage_monitor import bvm_pkg::*; #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [MV_W-1:0]      i_cfg_data,
    bvm_in_if.sink                    i_in_if,
    bvm_out_if.source                 o_out_if
);

    t_cfg            r_cfg;
    logic [MV_W-1:0] r_phase;
    logic [MV_W-1:0] n_phase;
    logic [MV_W:0]   phase_inc;
    logic            in_accept;
    logic            used;
    logic            mid_valid;
    logic            mid_ready;
    t_mv_word        mid_word;
    t_level          level;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period     <= RST_PERIOD;
            r_cfg.full_scale <= RST_FULL_SCALE;
            r_cfg.shift      <= RST_SHIFT;
            r_cfg.low_th     <= RST_LOW_TH;
            r_cfg.crit_th    <= RST_CRIT_TH;
            r_cfg.hyst       <= RST_HYST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD:     r_cfg.period     <= i_cfg_data;
                CFG_FULL_SCALE: r_cfg.full_scale <= i_cfg_data;
                CFG_SHIFT:      r_cfg.shift      <= i_cfg_data[SHIFT_W-1:0];
                CFG_LOW_TH:     r_cfg.low_th     <= i_cfg_data;
                CFG_CRIT_TH:    r_cfg.crit_th    <= i_cfg_data;
                CFG_HYST:       r_cfg.hyst       <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Frame phase: a frame is used at phase zero, wraps at the period
    assign in_accept = i_in_if.valid && i_in_if.ready;
    assign used      = (r_phase == '0);
    assign phase_inc = {1'b0, r_phase} + {{MV_W{1'b0}}, 1'b1};
    always_comb begin
        if (phase_inc >= {1'b0, r_cfg.period}) begin
            n_phase = '0;
        end else begin
            n_phase = phase_inc[MV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (in_accept) begin
            r_phase <= n_phase;
        end
    end

    // Input register and scaling
    bvm_scale #(
        .ADC_BITS (ADC_BITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_if.valid),
        .o_ready      (i_in_if.ready),
        .i_sample     (i_in_if.adc_sample),
        .i_used       (used),
        .i_full_scale (r_cfg.full_scale),
        .o_valid      (mid_valid),
        .i_ready      (mid_ready),
        .o_word       (mid_word)
    );

    // Filter, classification and result register
    bvm_filter u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (mid_valid),
        .o_ready       (mid_ready),
        .i_word        (mid_word),
        .i_cfg         (r_cfg),
        .o_valid       (o_out_if.valid),
        .i_ready       (o_out_if.ready),
        .o_filtered_mv (o_out_if.filtered_mv),
        .o_level       (level),
        .o_sample_used (o_out_if.sample_used)
    );

    assign o_out_if.battery_level = level;

endmodule
`default_nettype wire
